### sv/tvt_pkg.sv
package tvt_pkg;

  // Default configuration
  localparam int unsigned ENTRIES_DEF   = 64;
  localparam int unsigned TAG_BYTES_DEF = 8;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SUB_W    = 5;
  localparam int unsigned SUBS     = 32;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ  = 2'd0,
    FN_WRITE = 2'd1,
    FN_MARK  = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_NOT_FOUND     = 3'd0,
    STS_FOUND_CHANGED = 3'd1,
    STS_FOUND_SAME    = 3'd2,
    STS_WRITTEN       = 3'd3,
    STS_FULL          = 3'd4,
    STS_MARKED        = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_COMPARE,
    S_DONE
  } state_e;

  // Row write-back forms
  typedef enum logic [1:0] {
    WB_MARK,    // set the subscriber's flag
    WB_CLEAR,   // clear the subscriber's flag
    WB_UPDATE,  // new value, flags for everyone but the writer
    WB_APPEND   // new key, value and flags
  } wb_e;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    logic    wr_en;
    wb_e     wr_sel;
    logic    idx_inc;
    logic    res_load;
    status_e res_status;
    logic    res_hit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              key_empty;
    logic              idx_end;
    logic              full;
    logic              match;
    logic              flag;
  } sts_t;

endpackage

### sv/tvt_ram.sv
module tvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tvt_ctrl.sv
module tvt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tvt_pkg::sts_t sts_i,
  output tvt_pkg::cmd_t cmd_o
);

  tvt_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            miss;

  // Lookup ends without a hit when the scan passed the last valid row,
  // or when an empty key can never match
  assign miss = sts_i.idx_end ||
                (sts_i.key_empty && (sts_i.func != tvt_pkg::FN_MARK));

  always_comb begin
    state_d = state_q;
    case (state_q)
      tvt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tvt_pkg::S_LOOKUP;
      end
      tvt_pkg::S_LOOKUP: begin
        state_d = cmd_o.res_load ? tvt_pkg::S_DONE : tvt_pkg::S_COMPARE;
      end
      tvt_pkg::S_COMPARE: begin
        state_d = cmd_o.res_load ? tvt_pkg::S_DONE : tvt_pkg::S_LOOKUP;
      end
      tvt_pkg::S_DONE: begin
        if (cmd_o.out_load) state_d = tvt_pkg::S_IDLE;
      end
      default: state_d = tvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      tvt_pkg::S_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      tvt_pkg::S_LOOKUP: begin
        case (sts_i.func)
          tvt_pkg::FN_READ: begin
            if (miss) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = tvt_pkg::STS_NOT_FOUND;
            end else begin
              cmd_o.rd_en = 1'b1;
            end
          end
          tvt_pkg::FN_WRITE: begin
            if (miss) begin
              cmd_o.res_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = tvt_pkg::STS_FULL;
              end else begin
                cmd_o.res_status = tvt_pkg::STS_WRITTEN;
                cmd_o.wr_en      = !sts_i.key_empty;
                cmd_o.wr_sel     = tvt_pkg::WB_APPEND;
              end
            end else begin
              cmd_o.rd_en = 1'b1;
            end
          end
          tvt_pkg::FN_MARK: begin
            if (sts_i.idx_end) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = tvt_pkg::STS_MARKED;
            end else begin
              cmd_o.rd_en = 1'b1;
            end
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = tvt_pkg::STS_NOT_FOUND;
          end
        endcase
      end
      tvt_pkg::S_COMPARE: begin
        case (sts_i.func)
          tvt_pkg::FN_READ: begin
            if (sts_i.match) begin
              cmd_o.wr_en      = 1'b1;
              cmd_o.wr_sel     = tvt_pkg::WB_CLEAR;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_hit    = 1'b1;
              cmd_o.res_status = sts_i.flag ? tvt_pkg::STS_FOUND_CHANGED
                                            : tvt_pkg::STS_FOUND_SAME;
            end else begin
              cmd_o.idx_inc = 1'b1;
            end
          end
          tvt_pkg::FN_WRITE: begin
            if (sts_i.match) begin
              cmd_o.wr_en      = 1'b1;
              cmd_o.wr_sel     = tvt_pkg::WB_UPDATE;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = tvt_pkg::STS_WRITTEN;
            end else begin
              cmd_o.idx_inc = 1'b1;
            end
          end
          tvt_pkg::FN_MARK: begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = tvt_pkg::WB_MARK;
            cmd_o.idx_inc = 1'b1;
          end
          default: begin
            cmd_o.idx_inc = 1'b1;
          end
        endcase
      end
      tvt_pkg::S_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tvt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == tvt_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  a_compare_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tvt_pkg::S_COMPARE |-> $past(state_q) == tvt_pkg::S_LOOKUP)
    else $error("compare step without a preceding table read");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (state_q == tvt_pkg::S_LOOKUP || state_q == tvt_pkg::S_COMPARE))
    else $error("table write outside a scan");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped before it was taken");

endmodule

### sv/tvt_dp.sv
module tvt_dp #(
  parameter int unsigned ENTRIES   = tvt_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_BYTES = tvt_pkg::TAG_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tvt_pkg::cmd_t                 cmd_i,
  output tvt_pkg::sts_t                 sts_o,
  input  logic [tvt_pkg::FUNC_W-1:0]    func_i,
  input  logic [tvt_pkg::SUB_W-1:0]     subscriber_i,
  input  logic [tvt_pkg::KEY_W-1:0]     key_i,
  input  logic [tvt_pkg::VAL_W-1:0]     value_in_i,
  output logic [tvt_pkg::STATUS_W-1:0]  status_o,
  output logic [tvt_pkg::VAL_W-1:0]     value_out_o
);

  localparam int unsigned TW    = 8 * TAG_BYTES;
  localparam int unsigned VW    = tvt_pkg::VAL_W;
  localparam int unsigned NS    = tvt_pkg::SUBS;
  localparam int unsigned ROW_W = TW + VW + NS;
  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(ENTRIES + 1);

  logic [tvt_pkg::FUNC_W-1:0] func_q;
  logic [NS-1:0]              mask_q;
  logic [TW-1:0]              key_q, key_norm;
  logic [VW-1:0]              val_q;
  logic [CW-1:0]              idx_q, used_q;
  tvt_pkg::status_e           res_status_q;
  logic [VW-1:0]              res_value_q;
  logic [tvt_pkg::STATUS_W-1:0] out_status_q;
  logic [VW-1:0]              out_value_q;

  logic [ROW_W-1:0] rd_row, wr_row;
  logic [TW-1:0]    rd_key;
  logic [VW-1:0]    rd_val;
  logic [NS-1:0]    rd_chg;

  // Keep tag bytes up to the first zero byte
  always_comb begin
    logic live;
    live     = 1'b1;
    key_norm = '0;
    for (int b = 0; b < TAG_BYTES; b++) begin
      if (key_i[8*b +: 8] == 8'h00) live = 1'b0;
      if (live) key_norm[8*b +: 8] = key_i[8*b +: 8];
    end
  end

  assign rd_key = rd_row[TW-1:0];
  assign rd_val = rd_row[TW +: VW];
  assign rd_chg = rd_row[TW+VW +: NS];

  always_comb begin
    case (cmd_i.wr_sel)
      tvt_pkg::WB_MARK:   wr_row = {rd_chg | mask_q, rd_val, rd_key};
      tvt_pkg::WB_CLEAR:  wr_row = {rd_chg & ~mask_q, rd_val, rd_key};
      tvt_pkg::WB_UPDATE: wr_row = {~mask_q, val_q, rd_key};
      tvt_pkg::WB_APPEND: wr_row = {~mask_q, val_q, key_q};
      default:            wr_row = {rd_chg, rd_val, rd_key};
    endcase
  end

  tvt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .re_i    (cmd_i.rd_en),
    .addr_i  (idx_q[AW-1:0]),
    .wdata_i (wr_row),
    .rdata_o (rd_row)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      mask_q <= {{(NS-1){1'b0}}, 1'b1} << subscriber_i;
      key_q  <= key_norm;
      val_q  <= value_in_i;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= cmd_i.res_hit ? rd_val : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.wr_en && cmd_i.wr_sel == tvt_pkg::WB_APPEND) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.key_empty = (key_q[7:0] == 8'h00);
  assign sts_o.idx_end   = (idx_q == used_q);
  assign sts_o.full      = (used_q == CW'(ENTRIES));
  assign sts_o.match     = (rd_key == key_q);
  assign sts_o.flag      = |(rd_chg & mask_q);

  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(ENTRIES))
    else $error("fill count beyond table depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= used_q)
    else $error("scan index past the filled rows");

  a_used_append_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr_en && cmd_i.wr_sel == tvt_pkg::WB_APPEND) |=> $stable(used_q))
    else $error("fill count moved without an append");

endmodule

### sv/tagged_value_table_with_change_flags.sv
// Tagged value table with per-subscriber change flags. Each transaction
// carries an operation (read, write or insert, mark all changed), a
// subscriber index, a key and a value, and returns one result transaction
// with a status and a value. Rows are filled from row 0 with no gaps and
// live in a single-port table; a transaction scans the filled rows in order,
// reading each row examined and then comparing it and writing it back. One
// transaction is worked on at a time; the next is taken as soon as the
// previous result is parked in the output register, even if it has not
// been taken yet. The table needs no clearing after reset: only rows below
// the fill count are ever read.
module tagged_value_table_with_change_flags #(
  parameter int unsigned ENTRIES   = tvt_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_BYTES = tvt_pkg::TAG_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tvt_pkg::FUNC_W-1:0]    func_i,
  input  logic [tvt_pkg::SUB_W-1:0]     subscriber_i,
  input  logic [tvt_pkg::KEY_W-1:0]     key_i,
  input  logic [tvt_pkg::VAL_W-1:0]     value_in_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvt_pkg::STATUS_W-1:0]  status_o,
  output logic [tvt_pkg::VAL_W-1:0]     value_out_o
);

  // Command and status between the sequencer and the table datapath
  tvt_pkg::cmd_t cmd;
  tvt_pkg::sts_t sts;

  // Sequence the scan: accept, read/compare per row, park the result
  tvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the request, the table, the fill count and the result registers
  tvt_dp #(
    .ENTRIES   (ENTRIES),
    .TAG_BYTES (TAG_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .subscriber_i (subscriber_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .status_o     (status_o),
    .value_out_o  (value_out_o)
  );

endmodule
